// File: design/nozzle_flow_table_interpolator_top_macros.svh
// assertion helpers shared by the checker
`ifndef NOZZLE_FLOW_TABLE_INTERPOLATOR_TOP_MACROS_SVH
`define NOZZLE_FLOW_TABLE_INTERPOLATOR_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off while in reset
`define NFTI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nfti assertion failed");

// next-cycle implication, clocked on clk, off while in reset
`define NFTI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nfti assertion failed");

`endif

// File: design/nfti_pkg.sv
package nfti_pkg;

	localparam int CFG_DW = 4;
	localparam int CFG_IW = 1;
	localparam int FLOW_W = 20;

	localparam logic [CFG_IW-1:0] CFG_NOZZLE_TYPE = 1'b0;
	localparam logic [CFG_IW-1:0] CFG_VALVE_COUNT = 1'b1;

	localparam logic CMD_WRITE    = 1'b0;
	localparam logic CMD_ESTIMATE = 1'b1;

	typedef struct packed {
		logic        command;
		logic [15:0] pressure;
		logic [1:0]  entry_type;
		logic [3:0]  entry_index;
		logic [15:0] entry_flow;
	} in_word_t;

	typedef struct packed {
		logic [FLOW_W-1:0] flow;
		logic              clamped;
	} out_word_t;

	// control that rides along the pipeline with each word
	typedef struct packed {
		logic valid;
		logic est;
		logic clamp;
	} tag_t;

endpackage

// File: design/nfti_interp.sv
module nfti_interp (
	input  logic              clk,
	input  logic              arst_n,
	input  nfti_pkg::tag_t    tag,
	input  logic [15:0]       lo,
	input  logic [15:0]       hi,
	input  logic [7:0]        frac,
	input  logic [3:0]        valve_count,
	output nfti_pkg::out_word_t result,
	output logic              done
);

	nfti_pkg::tag_t tag_s3, tag_s4;
	logic [24:0] prod_lo_s3;
	logic [23:0] prod_hi_s3;
	logic [15:0] per_s4;
	logic [24:0] sum;
	nfti_pkg::out_word_t result_s5;
	logic done_s5;

	assign sum = prod_lo_s3 + 25'(prod_hi_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3  <= '0;
			tag_s4  <= '0;
			done_s5 <= 1'b0;
		end else begin
			tag_s3  <= tag;
			tag_s4  <= tag_s3;
			done_s5 <= tag_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_lo_s3 <= 25'(lo) * 25'(9'd256 - {1'b0, frac});
		prod_hi_s3 <= 24'(hi) * 24'(frac);
		// interpolated sum stays below 2^24, truncate the fraction
		per_s4 <= sum[23:8];
		if (tag_s4.est) begin
			result_s5.flow <= 20'(per_s4) * 20'(valve_count);
		end else begin
			result_s5.flow <= '0;
		end
		result_s5.clamped <= tag_s4.est & tag_s4.clamp;
	end

	assign result = result_s5;
	assign done   = done_s5;

endmodule

// File: design/nozzle_flow_table_interpolator_top.sv
// Nozzle flow table interpolator.
// Command channel: a word on sample is taken at a clock edge with start high
// and busy low. busy is always low, so a word may be issued every cycle.
// command write stores entry_flow in table entry_type at entry_index (out of
// range writes are dropped); command estimate interpolates the flow of the
// selected nozzle table at pressure and scales it by the valve count.
// Every accepted word gives exactly one result word: done is high for one
// cycle with result, once the word has passed the five-stage datapath; writes
// return flow 0. Throughput is one word per clock, set by the two-read-port
// table memory and that datapath (address, table read, products, sum, valve
// scaling).
// Configuration: cfg_we with cfg_index 0 sets nozzle_type, 1 sets valve_count;
// write only while no word is in flight.
// Reset clears the pipeline and sets nozzle_type 0 and valve_count 1; the
// flow tables hold no defined contents until loaded.
// The receiver cannot stall: result is valid only in the done cycle.
module nozzle_flow_table_interpolator_top #(
	parameter int TABLE_ENTRIES = 16,
	parameter int NOZZLE_TYPES  = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [nfti_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [nfti_pkg::CFG_DW-1:0]  cfg_data,
	input  logic                         start,
	output logic                         busy,
	input  nfti_pkg::in_word_t           sample,
	output logic                         done,
	output nfti_pkg::out_word_t          result
);

	localparam int DEPTH = NOZZLE_TYPES * TABLE_ENTRIES;
	localparam int AW    = $clog2(DEPTH);

	logic [1:0] nozzle_type_q;
	logic [3:0] valve_count_q;

	logic          accept;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [1:0]    t_sat;
	logic [AW-1:0] base;
	logic [7:0]    n;
	logic          clamp;
	logic [AW-1:0] addr_lo, addr_hi;
	logic [7:0]    frac;
	logic          lo_zero;

	logic [15:0]    flow_mem [DEPTH];

	nfti_pkg::tag_t tag_s1, tag_s2;
	logic [AW-1:0]  addr_lo_s1, addr_hi_s1;
	logic [7:0]     frac_s1, frac_s2;
	logic           lo_zero_s1, lo_zero_s2;
	logic [15:0]    lo_s2, hi_s2;
	logic [15:0]    lo_eff;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nozzle_type_q <= 2'd0;
			valve_count_q <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nfti_pkg::CFG_NOZZLE_TYPE: nozzle_type_q <= cfg_data[1:0];
				nfti_pkg::CFG_VALVE_COUNT: valve_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign wr_en = accept && (sample.command == nfti_pkg::CMD_WRITE)
		&& (int'(sample.entry_type) < NOZZLE_TYPES)
		&& (int'(sample.entry_index) < TABLE_ENTRIES);
	assign wr_addr = AW'(int'(sample.entry_type) * TABLE_ENTRIES
		+ int'(sample.entry_index));

	always_comb begin
		if (int'(nozzle_type_q) >= NOZZLE_TYPES) begin
			t_sat = 2'(NOZZLE_TYPES - 1);
		end else begin
			t_sat = nozzle_type_q;
		end
		base  = AW'(int'(t_sat) * TABLE_ENTRIES);
		n     = sample.pressure[15:8];
		clamp = int'(n) >= TABLE_ENTRIES;
		if (clamp) begin
			// both reads hit the last entry, zero fraction picks it as is
			addr_hi = base + AW'(TABLE_ENTRIES - 1);
			addr_lo = addr_hi;
			frac    = 8'd0;
			lo_zero = 1'b0;
		end else begin
			addr_hi = base + AW'(n);
			frac    = sample.pressure[7:0];
			lo_zero = (n == 8'd0);
			if (lo_zero) begin
				addr_lo = base;
			end else begin
				addr_lo = base + AW'(n) - AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1.valid <= accept;
			tag_s1.est   <= sample.command == nfti_pkg::CMD_ESTIMATE;
			tag_s1.clamp <= clamp;
			tag_s2       <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_lo_s1 <= addr_lo;
		addr_hi_s1 <= addr_hi;
		frac_s1    <= frac;
		lo_zero_s1 <= lo_zero;
		frac_s2    <= frac_s1;
		lo_zero_s2 <= lo_zero_s1;
	end

	// write at accept, table reads in the following cycle see it
	always_ff @(posedge clk) begin
		if (wr_en) begin
			flow_mem[wr_addr] <= sample.entry_flow;
		end
		lo_s2 <= flow_mem[addr_lo_s1];
		hi_s2 <= flow_mem[addr_hi_s1];
	end

	assign lo_eff = lo_zero_s2 ? 16'd0 : lo_s2;

	nfti_interp u_interp (
		.clk         (clk),
		.arst_n      (arst_n),
		.tag         (tag_s2),
		.lo          (lo_eff),
		.hi          (hi_s2),
		.frac        (frac_s2),
		.valve_count (valve_count_q),
		.result      (result),
		.done        (done)
	);

endmodule

// File: design/nfti_checker.sv
`include "nozzle_flow_table_interpolator_top_macros.svh"

module nfti_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input nfti_pkg::in_word_t          sample,
	input logic                        done,
	input nfti_pkg::out_word_t         result
);

	`NFTI_ASSERT_NOW(a_never_busy, 1'b1, !busy)
	`NFTI_ASSERT_NOW(a_done_has_word, done, $past(start && !busy, 5))
	`NFTI_ASSERT_NEXT(a_word_gets_done, start && !busy, ##4 done)
	`NFTI_ASSERT_NOW(a_write_zero, done && $past(sample.command == nfti_pkg::CMD_WRITE, 5), result.flow == '0 && !result.clamped)

endmodule

bind nozzle_flow_table_interpolator_top nfti_checker u_nfti_checker (.*);
